/* rtl/tm_pkg.sv */
`timescale 1ns / 1ps

package tm_pkg;

    localparam int MAX_PAIRS = 65536;

    localparam int COORD_W = 24;
    localparam int COEF_W  = 18;
    localparam int TRANS_W = 20;
    localparam int DIFF_W  = 30;
    localparam int SQ_W    = 60;
    localparam int D2_W    = 61;
    localparam int INV_W   = 31;
    localparam int LEN_W   = 16;
    localparam int SUM_W   = 41;
    localparam int SCORE_W = 25;
    localparam int DIV_W   = 49;
    localparam int DIV_CNT_W = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 60;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

    localparam longint unsigned SUM_CAP_FULL = longint'(MAX_PAIRS) << 24;
    localparam longint unsigned SUM_W_MAX    = (64'd1 << SUM_W) - 64'd1;
    localparam logic [SUM_W-1:0] SUM_CAP =
        SUM_W'((SUM_CAP_FULL > SUM_W_MAX) ? SUM_W_MAX : SUM_CAP_FULL);

    localparam logic [DIV_W-1:0] ONE_Q24 = DIV_W'(64'd1 << 24);
    localparam logic [DIV_W-1:0] R_CAP   = DIV_W'(64'd1 << 48);
    localparam logic [59:0]      HI_LIMIT = 60'(64'd1 << 36);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROT_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Q_INV   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_T_INV   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_Q_LEN   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_T_LEN   = 3'd7;

    typedef struct packed {
        logic [53:0]      rot_x;
        logic [53:0]      rot_y;
        logic [53:0]      rot_z;
        logic [59:0]      trans;
        logic [INV_W-1:0] q_inv;
        logic [INV_W-1:0] t_inv;
        logic [LEN_W-1:0] q_len;
        logic [LEN_W-1:0] t_len;
    } cfg_t;

    typedef struct packed {
        logic [D2_W-1:0] d2;
        logic            observed;
        logic            last;
    } pair_t;

    // Denominator 1 + d2/d0^2 in Q.24 from the two partial products.
    function automatic logic [DIV_W-1:0] term_den(input logic [59:0] hi,
                                                  input logic [62:0] lo);
        logic [DIV_W-1:0] r;
        begin
            if (hi >= HI_LIMIT)
            begin
                r = R_CAP;
            end
            else
            begin
                r = {1'b0, hi[35:0], 12'b0} + DIV_W'(lo >> 20);
                if (r > R_CAP)
                begin
                    r = R_CAP;
                end
            end
            term_den = ONE_Q24 + r;
        end
    endfunction

    function automatic logic [SCORE_W-1:0] clamp_score(input logic [DIV_W-1:0] q);
        begin
            clamp_score = (q > ONE_Q24) ? SCORE_W'(ONE_Q24) : q[SCORE_W-1:0];
        end
    endfunction

endpackage

/* rtl/tm_score_accumulator.sv */
`timescale 1ns / 1ps

// TM-score accumulator.
// Input channel: one aligned residue pair per transaction (query and target
// coordinates in 1/256 angstrom, an observed flag and a last flag), taken when
// in_valid is high and in_stall is low. Output channel: one result transaction
// per alignment, carrying both normalized scores (Q1.24) and zero-length status.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data) and should
// only be written while no alignment is in flight.
// The front part steps each pair through multiply, add, square and push
// states for the transform and squared distance and takes no new pair
// until it is idle again. The back part forms each observed pair's score
// term with two 49-step serial dividers, skips them for unobserved pairs,
// and on the last pair divides the sums by the lengths. A two-entry queue
// separates the parts. Reset restores the identity superposition, unit
// scales and zero lengths, and clears both sums. A stalled result waits in
// its output register while the block keeps scoring new pairs, up to the
// next final division, which waits until the result has been taken.
module tm_score_accumulator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [tm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [tm_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [tm_pkg::COORD_W-1:0]    query_x,
    input  logic signed [tm_pkg::COORD_W-1:0]    query_y,
    input  logic signed [tm_pkg::COORD_W-1:0]    query_z,
    input  logic signed [tm_pkg::COORD_W-1:0]    target_x,
    input  logic signed [tm_pkg::COORD_W-1:0]    target_y,
    input  logic signed [tm_pkg::COORD_W-1:0]    target_z,
    input  logic                                 pair_observed,
    input  logic                                 last_pair,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [tm_pkg::SCORE_W-1:0]           query_score,
    output logic                                 query_status,
    output logic [tm_pkg::SCORE_W-1:0]           target_score,
    output logic                                 target_status
);

    tm_pkg::cfg_t  cfg_reg;
    tm_pkg::pair_t push_data;
    tm_pkg::pair_t head;
    logic          push, pop, full, empty;

    // Configuration registers; reset gives the identity superposition.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rot_x <= 54'h10000;
            cfg_reg.rot_y <= 54'h10000 << 18;
            cfg_reg.rot_z <= 54'h10000 << 36;
            cfg_reg.trans <= '0;
            cfg_reg.q_inv <= 31'h4000_0000;
            cfg_reg.t_inv <= 31'h4000_0000;
            cfg_reg.q_len <= '0;
            cfg_reg.t_len <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tm_pkg::REG_ROT_X: cfg_reg.rot_x <= cfg_data[53:0];
                tm_pkg::REG_ROT_Y: cfg_reg.rot_y <= cfg_data[53:0];
                tm_pkg::REG_ROT_Z: cfg_reg.rot_z <= cfg_data[53:0];
                tm_pkg::REG_TRANS: cfg_reg.trans <= cfg_data[59:0];
                tm_pkg::REG_Q_INV: cfg_reg.q_inv <= cfg_data[tm_pkg::INV_W-1:0];
                tm_pkg::REG_T_INV: cfg_reg.t_inv <= cfg_data[tm_pkg::INV_W-1:0];
                tm_pkg::REG_Q_LEN: cfg_reg.q_len <= cfg_data[tm_pkg::LEN_W-1:0];
                tm_pkg::REG_T_LEN: cfg_reg.t_len <= cfg_data[tm_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    tm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .query_x       (query_x),
        .query_y       (query_y),
        .query_z       (query_z),
        .target_x      (target_x),
        .target_y      (target_y),
        .target_z      (target_z),
        .pair_observed (pair_observed),
        .last_pair     (last_pair),
        .q_full        (full),
        .q_push        (push),
        .q_data        (push_data)
    );

    tm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    tm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_empty       (empty),
        .q_head        (head),
        .q_pop         (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .query_score   (query_score),
        .query_status  (query_status),
        .target_score  (target_score),
        .target_status (target_status)
    );

endmodule

/* rtl/tm_div.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module tm_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [tm_pkg::DIV_W-1:0]  num,
    input  logic [tm_pkg::DIV_W-1:0]  den,
    output logic                      done,
    output logic [tm_pkg::DIV_W-1:0]  quo
);

    logic                           busy_reg;
    logic                           done_reg;
    logic [tm_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [tm_pkg::DIV_W-1:0]       rem_reg;
    logic [tm_pkg::DIV_W-1:0]       quo_reg;
    logic [tm_pkg::DIV_W-1:0]       den_reg;
    logic [tm_pkg::DIV_W:0]         rem_shift;
    logic                           fits;

    assign rem_shift = {rem_reg, quo_reg[tm_pkg::DIV_W-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == tm_pkg::DIV_LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= tm_pkg::DIV_W'(rem_shift - {1'b0, den_reg});
            end
            else
            begin
                rem_reg <= rem_shift[tm_pkg::DIV_W-1:0];
            end
            quo_reg <= {quo_reg[tm_pkg::DIV_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

/* rtl/tm_queue.sv */
`timescale 1ns / 1ps

// Two-entry queue between the geometry front and the scoring back.
module tm_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tm_pkg::pair_t push_data,
    input  logic          pop,
    output tm_pkg::pair_t head,
    output logic          full,
    output logic          empty
);

    tm_pkg::pair_t mem_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;

endmodule

/* rtl/tm_front.sv */
`timescale 1ns / 1ps

// Accepts a pair, applies the superposition and forms the squared distance.
module tm_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tm_pkg::cfg_t                       cfg,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [tm_pkg::COORD_W-1:0]  query_x,
    input  logic signed [tm_pkg::COORD_W-1:0]  query_y,
    input  logic signed [tm_pkg::COORD_W-1:0]  query_z,
    input  logic signed [tm_pkg::COORD_W-1:0]  target_x,
    input  logic signed [tm_pkg::COORD_W-1:0]  target_y,
    input  logic signed [tm_pkg::COORD_W-1:0]  target_z,
    input  logic                               pair_observed,
    input  logic                               last_pair,
    input  logic                               q_full,
    output logic                               q_push,
    output tm_pkg::pair_t                      q_data
);

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_MUL  = 5'b00010,
        F_ADD  = 5'b00100,
        F_SQ   = 5'b01000,
        F_PUSH = 5'b10000
    } fstate_t;

    fstate_t state_reg, state_next;

    logic signed [tm_pkg::COORD_W-1:0] q_reg [3];
    logic signed [tm_pkg::COORD_W-1:0] t_reg [3];
    logic                              obs_reg;
    logic                              last_reg;
    logic signed [41:0]                prod_reg [3][3];
    logic signed [tm_pkg::DIFF_W-1:0]  diff_reg [3];
    logic [tm_pkg::SQ_W-1:0]           sq_reg [3];

    logic [53:0]                       rows [3];
    logic signed [41:0]                prod_next [3][3];
    logic signed [tm_pkg::DIFF_W-1:0]  diff_next [3];
    logic signed [tm_pkg::SQ_W-1:0]    sq_next [3];
    logic signed [43:0]                acc [3];
    logic signed [tm_pkg::DIFF_W-1:0]  moved [3];

    assign rows[0] = cfg.rot_x;
    assign rows[1] = cfg.rot_y;
    assign rows[2] = cfg.rot_z;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_next[a][c] = $signed(rows[a][c*tm_pkg::COEF_W +: tm_pkg::COEF_W])
                                  * t_reg[c];
            end
            acc[a] = 44'(prod_reg[a][0]) + 44'(prod_reg[a][1]) + 44'(prod_reg[a][2])
                     + 44'sd32768;
            // Arithmetic shift gives the floor of the rounded sum.
            moved[a] = tm_pkg::DIFF_W'($signed(acc[a][43:16]))
                       + tm_pkg::DIFF_W'($signed(cfg.trans[a*tm_pkg::TRANS_W +:
                                                           tm_pkg::TRANS_W]));
            diff_next[a] = tm_pkg::DIFF_W'(q_reg[a]) - moved[a];
            sq_next[a]   = diff_reg[a] * diff_reg[a];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (in_valid) state_next = F_MUL;
            F_MUL:  state_next = F_ADD;
            F_ADD:  state_next = F_SQ;
            F_SQ:   state_next = F_PUSH;
            F_PUSH: if (!q_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && in_valid)
        begin
            q_reg[0] <= query_x;
            q_reg[1] <= query_y;
            q_reg[2] <= query_z;
            t_reg[0] <= target_x;
            t_reg[1] <= target_y;
            t_reg[2] <= target_z;
            obs_reg  <= pair_observed;
            last_reg <= last_pair;
        end
        if (state_reg == F_MUL)
        begin
            prod_reg <= prod_next;
        end
        if (state_reg == F_ADD)
        begin
            diff_reg <= diff_next;
        end
        if (state_reg == F_SQ)
        begin
            for (int a = 0; a < 3; a++)
            begin
                sq_reg[a] <= tm_pkg::SQ_W'(sq_next[a]);
            end
        end
    end

    assign in_stall        = state_reg != F_IDLE;
    assign q_push          = (state_reg == F_PUSH) && !q_full;
    assign q_data.d2       = tm_pkg::D2_W'(sq_reg[0]) + tm_pkg::D2_W'(sq_reg[1])
                             + tm_pkg::D2_W'(sq_reg[2]);
    assign q_data.observed = obs_reg;
    assign q_data.last     = last_reg;

endmodule

/* rtl/tm_back.sv */
`timescale 1ns / 1ps

// Turns squared distances into score terms, accumulates them and divides
// the sums by the lengths at the end of an alignment.
module tm_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tm_pkg::cfg_t                      cfg,
    input  logic                              q_empty,
    input  tm_pkg::pair_t                     q_head,
    output logic                              q_pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tm_pkg::SCORE_W-1:0]        query_score,
    output logic                              query_status,
    output logic [tm_pkg::SCORE_W-1:0]        target_score,
    output logic                              target_status
);

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_MUL  = 6'b000010,
        B_DEN  = 6'b000100,
        B_TDIV = 6'b001000,
        B_CHK  = 6'b010000,
        B_FDIV = 6'b100000
    } bstate_t;

    bstate_t state_reg, state_next;

    tm_pkg::pair_t                 cur_reg;
    logic [62:0]                   q_lo_reg, t_lo_reg;
    logic [59:0]                   q_hi_reg, t_hi_reg;
    logic [tm_pkg::SUM_W-1:0]      q_sum_reg, t_sum_reg;
    logic                          out_valid_reg;
    logic [tm_pkg::SCORE_W-1:0]    q_score_reg, t_score_reg;
    logic                          q_status_reg, t_status_reg;

    logic                          div_start;
    logic [tm_pkg::DIV_W-1:0]      q_num, t_num, q_den, t_den;
    logic [tm_pkg::DIV_W-1:0]      q_term_den, t_term_den;
    logic                          q_done, t_done;
    logic [tm_pkg::DIV_W-1:0]      q_quo, t_quo;
    logic [tm_pkg::SUM_W:0]        q_add, t_add;

    tm_div u_q_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (q_num),
        .den   (q_den),
        .done  (q_done),
        .quo   (q_quo)
    );

    tm_div u_t_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (t_num),
        .den   (t_den),
        .done  (t_done),
        .quo   (t_quo)
    );

    assign q_term_den = tm_pkg::term_den(q_hi_reg, q_lo_reg);
    assign t_term_den = tm_pkg::term_den(t_hi_reg, t_lo_reg);

    always_comb
    begin
        if (state_reg == B_DEN)
        begin
            q_den = q_term_den;
            t_den = t_term_den;
            q_num = tm_pkg::R_CAP + (q_term_den >> 1);
            t_num = tm_pkg::R_CAP + (t_term_den >> 1);
        end
        else
        begin
            q_den = tm_pkg::DIV_W'(cfg.q_len);
            t_den = tm_pkg::DIV_W'(cfg.t_len);
            q_num = tm_pkg::DIV_W'(q_sum_reg);
            t_num = tm_pkg::DIV_W'(t_sum_reg);
        end
    end

    assign div_start = (state_reg == B_DEN)
                       || (state_reg == B_CHK && cur_reg.last && !out_valid_reg);

    assign q_add = (tm_pkg::SUM_W+1)'(q_sum_reg) + (tm_pkg::SUM_W+1)'(q_quo[24:0]);
    assign t_add = (tm_pkg::SUM_W+1)'(t_sum_reg) + (tm_pkg::SUM_W+1)'(t_quo[24:0]);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (!q_empty) state_next = q_head.observed ? B_MUL : B_CHK;
            B_MUL:  state_next = B_DEN;
            B_DEN:  state_next = B_TDIV;
            B_TDIV: if (q_done) state_next = B_CHK;
            B_CHK:
            begin
                if (!cur_reg.last)
                begin
                    state_next = B_IDLE;
                end
                else if (!out_valid_reg)
                begin
                    state_next = B_FDIV;
                end
            end
            B_FDIV: if (q_done) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    assign q_pop = (state_reg == B_IDLE) && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            q_sum_reg     <= '0;
            t_sum_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_TDIV && q_done)
            begin
                if (cfg.q_len != '0)
                begin
                    q_sum_reg <= (q_add > (tm_pkg::SUM_W+1)'(tm_pkg::SUM_CAP))
                                 ? tm_pkg::SUM_CAP : q_add[tm_pkg::SUM_W-1:0];
                end
                if (cfg.t_len != '0)
                begin
                    t_sum_reg <= (t_add > (tm_pkg::SUM_W+1)'(tm_pkg::SUM_CAP))
                                 ? tm_pkg::SUM_CAP : t_add[tm_pkg::SUM_W-1:0];
                end
            end
            else if (state_reg == B_CHK && cur_reg.last && !out_valid_reg)
            begin
                q_sum_reg <= '0;
                t_sum_reg <= '0;
            end
            if (state_reg == B_FDIV && q_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_head;
        end
        if (state_reg == B_MUL)
        begin
            q_lo_reg <= 63'(cur_reg.d2[31:0]) * 63'(cfg.q_inv);
            t_lo_reg <= 63'(cur_reg.d2[31:0]) * 63'(cfg.t_inv);
            q_hi_reg <= 60'(cur_reg.d2[60:32]) * 60'(cfg.q_inv);
            t_hi_reg <= 60'(cur_reg.d2[60:32]) * 60'(cfg.t_inv);
        end
        if (state_reg == B_FDIV && q_done)
        begin
            q_status_reg <= cfg.q_len == '0;
            t_status_reg <= cfg.t_len == '0;
            q_score_reg  <= (cfg.q_len == '0) ? '0 : tm_pkg::clamp_score(q_quo);
            t_score_reg  <= (cfg.t_len == '0) ? '0 : tm_pkg::clamp_score(t_quo);
        end
    end

    assign out_valid     = out_valid_reg;
    assign query_score   = q_score_reg;
    assign query_status  = q_status_reg;
    assign target_score  = t_score_reg;
    assign target_status = t_status_reg;

    // The two dividers are started together and must finish together.
    assert property (@(posedge clk) disable iff (!rst_n) q_done == t_done)
        else $error("divider completion mismatch");

    assert property (@(posedge clk) disable iff (!rst_n)
        (q_sum_reg <= tm_pkg::SUM_CAP) && (t_sum_reg <= tm_pkg::SUM_CAP))
        else $error("term sum above cap");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == B_FDIV))
        else $error("result raised outside final division");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (state_reg == B_DEN) || !out_valid_reg)
        else $error("final division started with result pending");

endmodule

/* dv/tm_score_accumulator_test.sv */
`timescale 1ns / 1ps

// Self-checking testbench for the TM-score accumulator.
//
// Pairs are streamed through the valid/stall input channel in alignment-shaped
// bursts, each closed by a pair flagged as last. A scoreboard object keeps its
// own copy of the superposition, the scales, the lengths and the two running
// sums. It works out the expected score transaction whenever a last pair is
// accepted and compares every result transaction against the oldest one queued.
// The run walks through several configurations, including the reset values,
// a unit query length that forces the clamp, all-ones registers and a zero
// query scale. Each configuration is paired with one of four idling modes on
// the two channels.
module tm_score_accumulator_test;

    localparam int CLOCK_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic signed [23:0] qx, qy, qz, tx, ty, tz;
        logic               observed;
        logic               last;
    } align_pair_s;

    typedef struct packed {
        logic [24:0] q_score;
        logic        q_status;
        logic [24:0] t_score;
        logic        t_status;
    } tm_result_s;

    // Scoreboard: tracks register state and running sums, and holds the
    // score transactions that are still owed by the block.
    class tm_score_board;
        logic [53:0]     rot[3];
        logic [59:0]     trans;
        logic [30:0]     inv[2];
        logic [15:0]     len[2];
        longint unsigned sums[2];
        tm_result_s      owed[$];
        int              fails;

        function new();
            rot[0] = 54'd65536;
            rot[1] = 54'd65536 << 18;
            rot[2] = 54'd65536 << 36;
            trans = '0;
            inv[0] = 31'd1 << 30;
            inv[1] = 31'd1 << 30;
            len[0] = '0;
            len[1] = '0;
            sums[0] = 0;
            sums[1] = 0;
            fails = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [59:0] value);
            case (idx)
                tm_pkg::REG_ROT_X: rot[0] = value[53:0];
                tm_pkg::REG_ROT_Y: rot[1] = value[53:0];
                tm_pkg::REG_ROT_Z: rot[2] = value[53:0];
                tm_pkg::REG_TRANS: trans = value;
                tm_pkg::REG_Q_INV: inv[0] = value[30:0];
                tm_pkg::REG_T_INV: inv[1] = value[30:0];
                tm_pkg::REG_Q_LEN: len[0] = value[15:0];
                tm_pkg::REG_T_LEN: len[1] = value[15:0];
                default: ;
            endcase
        endfunction

        // One axis of the superposed target point, rounded half up.
        function longint moved_axis(logic [53:0] row, longint x, longint y, longint z,
                                    logic signed [19:0] shift);
            longint acc;
            acc = longint'($signed(row[17:0])) * x + longint'($signed(row[35:18])) * y
                + longint'($signed(row[53:36])) * z;
            acc = (acc + (64'sd1 <<< 15)) >>> 16;
            return acc + longint'(shift);
        endfunction

        // Score term 1/(1 + d2/d0^2) in Q1.24.
        function longint unsigned score_term(longint unsigned d2, longint unsigned scale);
            longint unsigned lo, hi, r, den;
            lo = (d2 & 64'hFFFF_FFFF) * scale;
            hi = (d2 >> 32) * scale;
            if (hi >= (64'd1 << 36))
            begin
                r = 64'd1 << 48;
            end
            else
            begin
                r = (hi << 12) + (lo >> 20);
                if (r > (64'd1 << 48))
                begin
                    r = 64'd1 << 48;
                end
            end
            den = (64'd1 << 24) + r;
            return ((64'd1 << 48) + (den >> 1)) / den;
        endfunction

        function void note_pair(align_pair_s p);
            longint dx, dy, dz;
            longint unsigned d2, s;
            tm_result_s res;
            if (p.observed)
            begin
                dx = longint'(p.qx) - moved_axis(rot[0], p.tx, p.ty, p.tz, trans[19:0]);
                dy = longint'(p.qy) - moved_axis(rot[1], p.tx, p.ty, p.tz, trans[39:20]);
                dz = longint'(p.qz) - moved_axis(rot[2], p.tx, p.ty, p.tz, trans[59:40]);
                d2 = longint'(dx * dx + dy * dy + dz * dz);
                for (int k = 0; k < 2; k++)
                begin
                    if (len[k] != 0)
                    begin
                        s = sums[k] + score_term(d2, inv[k]);
                        sums[k] = (s > (64'd65536 << 24)) ? (64'd65536 << 24) : s;
                    end
                end
            end
            if (p.last)
            begin
                res.q_status = (len[0] == 0);
                res.t_status = (len[1] == 0);
                res.q_score = (len[0] == 0) ? 25'd0
                    : 25'((sums[0] / len[0] > (64'd1 << 24)) ? (64'd1 << 24) : sums[0] / len[0]);
                res.t_score = (len[1] == 0) ? 25'd0
                    : 25'((sums[1] / len[1] > (64'd1 << 24)) ? (64'd1 << 24) : sums[1] / len[1]);
                owed.push_back(res);
                sums[0] = 0;
                sums[1] = 0;
            end
        endfunction

        function void check_result(tm_result_s got);
            tm_result_s exp;
            if (owed.size() == 0)
            begin
                fails++;
                if (fails <= 10)
                begin
                    $display("unexpected score transaction: q %0d/%0d t %0d/%0d",
                             got.q_score, got.q_status, got.t_score, got.t_status);
                end
                return;
            end
            exp = owed.pop_front();
            if (exp != got)
            begin
                fails++;
                if (fails <= 10)
                begin
                    $display("score mismatch: expected q %0d/%0d t %0d/%0d, got q %0d/%0d t %0d/%0d",
                             exp.q_score, exp.q_status, exp.t_score, exp.t_status,
                             got.q_score, got.q_status, got.t_score, got.t_status);
                end
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [2:0]          cfg_index = '0;
    logic [59:0]         cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic signed [23:0]  query_x = '0, query_y = '0, query_z = '0;
    logic signed [23:0]  target_x = '0, target_y = '0, target_z = '0;
    logic                pair_observed = 1'b0;
    logic                last_pair = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [24:0]         query_score, target_score;
    logic                query_status, target_status;

    tm_score_board sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycles = 0;

    tm_score_accumulator i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .query_x(query_x), .query_y(query_y), .query_z(query_z),
        .target_x(target_x), .target_y(target_y), .target_z(target_z),
        .pair_observed(pair_observed), .last_pair(last_pair),
        .out_valid(out_valid), .out_stall(out_stall),
        .query_score(query_score), .query_status(query_status),
        .target_score(target_score), .target_status(target_status)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // The run is bounded: a hang anywhere ends it as a failure.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CLOCK_LIMIT)
        begin
            $display("tm_score_accumulator_test NOT OK");
            $finish;
        end
    end

    // The receiver stalls at random; the decision is made at the falling edge.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Every result transaction is checked at the rising edge that takes it.
    always @(posedge clk)
    begin
        tm_result_s got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.q_score = query_score;
            got.q_status = query_status;
            got.t_score = target_score;
            got.t_status = target_status;
            sb.check_result(got);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [59:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    // Sends one pair; valid stays high into the next pair unless the sender
    // decides to idle first.
    task automatic send_pair(align_pair_s p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        query_x <= p.qx;
        query_y <= p.qy;
        query_z <= p.qz;
        target_x <= p.tx;
        target_y <= p.ty;
        target_z <= p.tz;
        pair_observed <= p.observed;
        last_pair <= p.last;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        sb.note_pair(p);
    endtask

    // Holds the sender off until every owed score has arrived, then lets the
    // back end settle so a register write finds the block idle.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.owed.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic align_pair_s make_pair(logic signed [23:0] qx, logic signed [23:0] qy,
                                              logic signed [23:0] qz, logic signed [23:0] tx,
                                              logic signed [23:0] ty, logic signed [23:0] tz,
                                              logic obs, logic fin);
        align_pair_s p;
        p.qx = qx; p.qy = qy; p.qz = qz;
        p.tx = tx; p.ty = ty; p.tz = tz;
        p.observed = obs;
        p.last = fin;
        return p;
    endfunction

    // Random pair: mostly near points so that terms are large, sometimes
    // full-range coordinates so that every bit toggles.
    function automatic align_pair_s random_pair(logic fin);
        align_pair_s p;
        int spread;
        if ($urandom_range(3) == 0)
        begin
            p.tx = 24'($urandom()); p.ty = 24'($urandom()); p.tz = 24'($urandom());
            p.qx = 24'($urandom()); p.qy = 24'($urandom()); p.qz = 24'($urandom());
        end
        else
        begin
            spread = 1 << $urandom_range(2, 12);
            p.tx = 24'($signed($urandom_range(8191)) - 4096);
            p.ty = 24'($signed($urandom_range(8191)) - 4096);
            p.tz = 24'($signed($urandom_range(8191)) - 4096);
            p.qx = 24'(p.tx + $signed($urandom_range(spread)) - spread / 2);
            p.qy = 24'(p.ty + $signed($urandom_range(spread)) - spread / 2);
            p.qz = 24'(p.tz + $signed($urandom_range(spread)) - spread / 2);
        end
        p.observed = ($urandom_range(7) != 0);
        p.last = fin;
        return p;
    endfunction

    task automatic random_config(int phase);
        logic [59:0] v;
        for (int r = 0; r < 3; r++)
        begin
            if (phase % 3 == 0)
            begin
                v = 60'd65536 << (18 * r);
            end
            else
            begin
                v = 60'({$urandom(), $urandom()});
            end
            write_reg(tm_pkg::REG_ROT_X + 3'(r), v);
        end
        v = 60'({$urandom(), $urandom()});
        write_reg(tm_pkg::REG_TRANS, (phase % 3 == 0) ? (v & 60'h00FF_00FF_00FF_00F) : v);
        write_reg(tm_pkg::REG_Q_INV, 60'($urandom_range(1 << 30)));
        write_reg(tm_pkg::REG_T_INV, 60'($urandom_range(1 << 30)));
        write_reg(tm_pkg::REG_Q_LEN, ($urandom_range(9) == 0) ? 60'd0 : 60'($urandom_range(1, 24)));
        write_reg(tm_pkg::REG_T_LEN, ($urandom_range(9) == 0) ? 60'($urandom_range(65535))
                                                              : 60'($urandom_range(1, 24)));
    endtask

    initial
    begin
        int sent;
        int n;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset configuration: both lengths are zero, so both scores report
        // zero-length status. Extreme coordinates and an unobserved last pair.
        send_pair(make_pair(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                            24'sh800000, 24'sh800000, 24'sh800000, 1'b1, 1'b0));
        send_pair(make_pair(24'sh800000, 24'sh800000, 24'sh800000,
                            24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1'b1, 1'b0));
        send_pair(make_pair(24'sh000000, 24'sh000000, 24'sh000000,
                            24'sh7FFFFF, 24'sh800000, 24'sh000001, 1'b0, 1'b1));
        send_pair(make_pair('0, '0, '0, '0, '0, '0, 1'b0, 1'b1));
        drain();

        // Unit query length: identical points give a sum of two, which must
        // clamp to one. An alignment of unobserved pairs scores zero.
        write_reg(tm_pkg::REG_Q_LEN, 60'd1);
        write_reg(tm_pkg::REG_T_LEN, 60'd3);
        send_pair(make_pair(24'sd100, -24'sd100, 24'sd5, 24'sd100, -24'sd100, 24'sd5, 1'b1, 1'b0));
        send_pair(make_pair(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                            24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1'b1, 1'b1));
        send_pair(make_pair(24'sd1, 24'sd2, 24'sd3, 24'sd4, 24'sd5, 24'sd6, 1'b0, 1'b0));
        send_pair(make_pair(24'sd1, 24'sd2, 24'sd3, 24'sd4, 24'sd5, 24'sd6, 1'b0, 1'b1));
        send_pair(make_pair(24'sh800000, 24'sh7FFFFF, 24'sh800000,
                            24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 1'b1, 1'b1));
        drain();

        // Extreme registers: every rotation coefficient is all ones (minus one LSB),
        // the translation is all ones, the query scale is zero and the target
        // scale is at its reset value.
        write_reg(tm_pkg::REG_ROT_X, {60{1'b1}});
        write_reg(tm_pkg::REG_ROT_Y, {60{1'b1}});
        write_reg(tm_pkg::REG_ROT_Z, {60{1'b1}});
        write_reg(tm_pkg::REG_TRANS, {60{1'b1}});
        write_reg(tm_pkg::REG_Q_INV, 60'd0);
        write_reg(tm_pkg::REG_T_INV, 60'd1 << 30);
        write_reg(tm_pkg::REG_Q_LEN, 60'd65535);
        write_reg(tm_pkg::REG_T_LEN, 60'd2);
        send_pair(make_pair(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF,
                            24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 1'b1, 1'b0));
        send_pair(make_pair(-24'sd3, -24'sd3, -24'sd3, 24'sd1, 24'sd1, 24'sd1, 1'b1, 1'b1));
        drain();

        // Random phases, each with its own configuration and idling mode.
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            random_config(phase);
            sent = 0;
            while (sent < 200)
            begin
                n = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
                for (int i = 0; i < n; i++)
                begin
                    // A stray last flag now and then cuts an alignment short.
                    send_pair(random_pair((i == n - 1) || ($urandom_range(49) == 0)));
                end
                sent += n;
            end
            drain();
        end

        if (sb.fails == 0 && sb.owed.size() == 0)
        begin
            $display("tm_score_accumulator_test OK");
        end
        else
        begin
            $display("tm_score_accumulator_test NOT OK");
        end
        $finish;
    end

endmodule
